// ===== rtl/core/cor_pkg.sv =====
package cor_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadW    = 11;
  localparam int unsigned ClipW   = 13;
  localparam int unsigned PitchW  = 14;
  localparam int unsigned SqW     = 2 * RadW;
  localparam int unsigned ExtW    = CoordW + 2;

  localparam logic [2:0] RegClipLeft   = 3'd0;
  localparam logic [2:0] RegClipTop    = 3'd1;
  localparam logic [2:0] RegClipRight  = 3'd2;
  localparam logic [2:0] RegClipBottom = 3'd3;
  localparam logic [2:0] RegRowPitch   = 3'd4;

  localparam logic ModeStart = 1'b0;

  typedef struct packed {
    logic                     mode;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [RadW-1:0]          radius;
  } in_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [24:0] pixel_index;
    logic        done_res;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic row_load;
    logic idx;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic row_wait;
    logic sqrt_done;
  } status_t;

endpackage

// ===== rtl/core/cor_isqrt.sv =====
module cor_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cor_pkg::SqW-1:0]       val_i,
  output logic                          done_o,
  output logic [cor_pkg::RadW-1:0]      root_o
);

  localparam int unsigned W = cor_pkg::SqW;

  logic [W-1:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [W-1:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = val_i;
      res_d  = '0;
      bit_d  = W'(1) << (W - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one result bit per cycle
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[cor_pkg::RadW-1:0];

endmodule

// ===== rtl/core/cor_dp.sv =====
module cor_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cor_pkg::cmd_t         cmd_i,
  output cor_pkg::status_t      status_o,
  input  cor_pkg::in_t          in_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [13:0]           cfg_data_i,
  output cor_pkg::out_t         out_o
);

  localparam int unsigned EW = cor_pkg::ExtW;
  localparam int unsigned CW = cor_pkg::ClipW;

  logic [CW-1:0]                 clip_l_q, clip_t_q, clip_r_q, clip_b_q;
  logic [cor_pkg::PitchW-1:0]    pitch_q;

  logic                          active_q;
  logic signed [cor_pkg::CoordW-1:0] cc_q, cr_q;
  logic [cor_pkg::RadW-1:0]      r_q, h_q;
  logic [11:0]                   d_q;
  logic signed [12:0]            run_q, prev_q;
  logic [1:0]                    phase_q;
  logic [cor_pkg::SqW-1:0]       v_q;
  logic [CW-1:0]                 px_q, py_q;
  logic                          pdone_q;
  cor_pkg::out_t                 out_q;

  logic                          upper, left_side, row_ok, col_ok, skip, last_row;
  logic signed [EW-1:0]          row, col, run_ext;
  logic signed [12:0]            neg_h;
  logic [cor_pkg::SqW-1:0]       rr, v_next;
  logic [12:0]                   d_inc;
  logic                          sqrt_go, sqrt_done;
  logic [cor_pkg::RadW-1:0]      root;
  logic [26:0]                   prod;

  assign upper     = !phase_q[1];
  assign left_side = !phase_q[0];
  assign neg_h     = -$signed({2'b00, h_q});
  assign run_ext   = EW'(run_q);
  assign row = upper ? (EW'(cr_q) - $signed({{(EW-12){1'b0}}, d_q}))
                     : (EW'(cr_q) + $signed({{(EW-12){1'b0}}, d_q}));
  assign col = left_side ? (EW'(cc_q) + run_ext) : (EW'(cc_q) - run_ext);
  assign row_ok = (row >= $signed({{(EW-CW){1'b0}}, clip_t_q}))
               && (row <  $signed({{(EW-CW){1'b0}}, clip_b_q}));
  assign col_ok = (col >= $signed({{(EW-CW){1'b0}}, clip_l_q}))
               && (col <  $signed({{(EW-CW){1'b0}}, clip_r_q}));
  assign skip     = !row_ok || (run_q > neg_h);
  assign d_inc    = {1'b0, d_q} + 13'd1;
  assign last_row = d_inc > {2'b00, r_q};
  assign rr       = in_i.radius * in_i.radius;
  assign v_next   = v_q - cor_pkg::SqW'({d_q, 1'b1});
  assign sqrt_go  = cmd_i.step && active_q && skip && !upper && !last_row;

  assign status_o.emit      = cmd_i.step && (!active_q || (!skip && col_ok));
  assign status_o.row_wait  = sqrt_go;
  assign status_o.sqrt_done = sqrt_done;

  cor_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go),
    .val_i   (v_next),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_l_q <= '0;
      clip_t_q <= '0;
      clip_r_q <= CW'(4096);
      clip_b_q <= CW'(4096);
      pitch_q  <= cor_pkg::PitchW'(4096);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cor_pkg::RegClipLeft:   clip_l_q <= cfg_data_i[CW-1:0];
        cor_pkg::RegClipTop:    clip_t_q <= cfg_data_i[CW-1:0];
        cor_pkg::RegClipRight:  clip_r_q <= cfg_data_i[CW-1:0];
        cor_pkg::RegClipBottom: clip_b_q <= cfg_data_i[CW-1:0];
        cor_pkg::RegRowPitch:   pitch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cc_q     <= '0;
      cr_q     <= '0;
      r_q      <= '0;
      d_q      <= '0;
      run_q    <= '0;
      prev_q   <= '0;
      h_q      <= '0;
      phase_q  <= '0;
      v_q      <= '0;
    end else if (cmd_i.load) begin
      active_q <= 1'b1;
      cc_q     <= in_i.center_x;
      cr_q     <= in_i.center_y;
      r_q      <= in_i.radius;
      d_q      <= '0;
      prev_q   <= -$signed({2'b00, in_i.radius});
      run_q    <= -$signed({2'b00, in_i.radius});
      h_q      <= in_i.radius;
      phase_q  <= '0;
      v_q      <= rr;
    end else if (cmd_i.row_load) begin
      h_q     <= root;
      run_q   <= prev_q;
      phase_q <= '0;
    end else if (cmd_i.step && active_q) begin
      if (skip) begin
        if (upper) begin
          phase_q <= 2'd2;
          run_q   <= prev_q;
        end else begin
          prev_q <= neg_h;
          d_q    <= d_inc[11:0];
          v_q    <= v_next;
          if (last_row) begin
            active_q <= 1'b0;
          end
        end
      end else if (left_side) begin
        phase_q <= phase_q + 2'd1;
      end else begin
        phase_q <= phase_q - 2'd1;
        run_q   <= run_q + 13'sd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (status_o.emit) begin
      pdone_q <= !active_q;
      px_q    <= active_q ? col[CW-1:0] : '0;
      py_q    <= active_q ? row[CW-1:0] : '0;
    end
  end

  assign prod = 27'(py_q) * 27'(pitch_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx) begin
      out_q.pixel_valid <= !pdone_q;
      out_q.pixel_x     <= px_q[11:0];
      out_q.pixel_y     <= py_q[11:0];
      out_q.pixel_index <= 25'(prod + 27'(px_q));
      out_q.done_res    <= pdone_q;
    end
  end

  assign out_o = out_q;

endmodule

// ===== rtl/core/cor_ctrl.sv =====
module cor_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cor_pkg::cmd_t     cmd_o,
  input  cor_pkg::status_t  status_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_IDX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       in_xfer;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o          = '0;
    state_d        = state_q;
    cmd_o.load     = in_xfer && (in_mode_i == cor_pkg::ModeStart);
    cmd_o.step     = (state_q == S_STEP);
    cmd_o.row_load = (state_q == S_SQRT) && status_i.sqrt_done;
    cmd_o.idx      = (state_q == S_IDX);
    case (state_q)
      S_IDLE: if (in_xfer && in_mode_i != cor_pkg::ModeStart) state_d = S_STEP;
      S_STEP: begin
        if (status_i.emit) state_d = S_IDX;
        else if (status_i.row_wait) state_d = S_SQRT;
      end
      S_SQRT: if (status_i.sqrt_done) state_d = S_STEP;
      S_IDX:  state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  a_row_to_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && status_i.row_wait && !status_i.emit) |=> (state_q == S_SQRT))
    else $error("row root not awaited");

  a_sqrt_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.sqrt_done |-> (state_q == S_SQRT)) else $error("stray root result");

  a_idx_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.idx |=> out_valid_o) else $error("result not presented");

endmodule

// ===== rtl/core/circle_outline_rasterizer.sv =====
// a start item gives no result
// a next item steps the walk once per clipped pixel or skipped upper row, waits for an
// 11-step integer square root on each new row, then forms the index and presents its result
// the next item is taken only after the result transfer
// reset: asynchronous, active low; no circle active, clip 0..4096, pitch 4096
module circle_outline_rasterizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cor_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cor_pkg::out_t  out_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [13:0]    cfg_data_i
);

  cor_pkg::cmd_t    cmd;
  cor_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  cor_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cor_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_i        (in_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

endmodule

// ===== test/circle_outline_rasterizer_tb.sv =====
`timescale 1ns / 100ps

module circle_outline_rasterizer_tb;

  localparam longint CycleLimit = 100000000;
  localparam int     DrainWait  = 40;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  cor_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  cor_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [13:0]   cfg_data = '0;

  circle_outline_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of clip window and circle walk
  logic [12:0] win_left, win_top, win_right, win_bottom;
  logic [13:0] pitch;
  bit          walking;
  longint      ctr_col, ctr_row;
  int          rad, row_d, run_o, prev_left, half_w, phase;
  bit          last_done;

  cor_pkg::out_t pixel_q[$];
  int     err_cnt = 0;
  int     n_items = 0;
  int     n_pixels = 0;
  int     n_dones = 0;
  longint cyc = 0;
  longint hold_until = 0;
  bit     idle_on = 1'b1;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("timeout after %0d cycles", cyc);
      $display("FAIL circle_outline_rasterizer");
      $finish;
    end
  end

  task automatic report_err(input string msg);
    err_cnt++;
    $display("mismatch at cycle %0d: %s", cyc, msg);
  endtask

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (cyc < hold_until) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk_i) begin
    cor_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report_err("result with nothing expected");
      end else begin
        want = pixel_q.pop_front();
        if (out_data.pixel_valid !== want.pixel_valid)
          report_err($sformatf("pixel_valid %b want %b", out_data.pixel_valid,
                               want.pixel_valid));
        if (out_data.pixel_x !== want.pixel_x)
          report_err($sformatf("pixel_x %0d want %0d", out_data.pixel_x, want.pixel_x));
        if (out_data.pixel_y !== want.pixel_y)
          report_err($sformatf("pixel_y %0d want %0d", out_data.pixel_y, want.pixel_y));
        if (out_data.pixel_index !== want.pixel_index)
          report_err($sformatf("pixel_index %0d want %0d", out_data.pixel_index,
                               want.pixel_index));
        if (out_data.done_res !== want.done_res)
          report_err($sformatf("done_res %b want %b", out_data.done_res, want.done_res));
      end
    end
  end

  function automatic int int_sqrt(input longint v);
    int r = 0;
    for (int b = 11; b >= 0; b--) begin
      if (longint'(r | (1 << b)) * longint'(r | (1 << b)) <= v) r = r | (1 << b);
    end
    return r;
  endfunction

  function automatic bit in_win(input longint v, input logic [12:0] lo, input logic [12:0] hi);
    return v >= longint'(lo) && v < longint'(hi);
  endfunction

  function automatic void start_row();
    half_w = int_sqrt(longint'(rad) * rad - longint'(row_d) * row_d);
    run_o  = prev_left;
    phase  = 0;
  endfunction

  task automatic predict_item(input cor_pkg::in_t it);
    cor_pkg::out_t res;
    longint row, col;
    bit     upper, left_side, found;
    if (it.mode == cor_pkg::ModeStart) begin
      ctr_col   = longint'(it.center_x);
      ctr_row   = longint'(it.center_y);
      rad       = it.radius;
      row_d     = 0;
      prev_left = -rad;
      walking   = 1'b1;
      start_row();
      return;
    end
    res = '0;
    found = 1'b0;
    while (walking && !found) begin
      upper = phase < 2;
      row = upper ? ctr_row - row_d : ctr_row + row_d;
      if (!in_win(row, win_top, win_bottom) || run_o > -half_w) begin
        if (upper) begin
          phase = 2;
          run_o = prev_left;
        end else begin
          prev_left = -half_w;
          row_d++;
          if (row_d > rad) walking = 1'b0;
          else start_row();
        end
      end else begin
        left_side = (phase % 2) == 0;
        col = left_side ? ctr_col + run_o : ctr_col - run_o;
        if (left_side) begin
          phase++;
        end else begin
          phase--;
          run_o++;
        end
        if (in_win(col, win_left, win_right)) begin
          found = 1'b1;
          res.pixel_valid = 1'b1;
          res.pixel_x     = col[11:0];
          res.pixel_y     = row[11:0];
          res.pixel_index = 25'(row * longint'(pitch) + col);
        end
      end
    end
    if (!found) begin
      res.done_res = 1'b1;
      n_dones++;
    end else begin
      n_pixels++;
    end
    last_done = !found;
    pixel_q.push_back(res);
  endtask

  // leaves valid high; caller sends again or calls in_quiet in the same step
  task automatic send_item(input cor_pkg::in_t it);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    n_items++;
    predict_item(it);
  endtask

  task automatic in_quiet();
    in_valid <= 1'b0;
  endtask

  task automatic start_circle(input int cx, input int cy, input int r);
    cor_pkg::in_t it;
    it.mode     = cor_pkg::ModeStart;
    it.center_x = 16'(cx);
    it.center_y = 16'(cy);
    it.radius   = 11'(r);
    send_item(it);
  endtask

  task automatic next_pixel();
    cor_pkg::in_t it;
    logic [63:0]  raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(cor_pkg::in_t)-1:0];
    it.mode = ~cor_pkg::ModeStart;
    send_item(it);
  endtask

  task automatic walk_circle(input int max_steps);
    int k = 0;
    last_done = 1'b0;
    while (!last_done && k < max_steps) begin
      next_pixel();
      k++;
    end
  endtask

  task automatic wait_idle();
    in_quiet();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_window(input int l, input int t, input int r, input int b,
                            input int p);
    logic [13:0] vals[5];
    logic [2:0]  idx[5];
    vals = '{14'(l), 14'(t), 14'(r), 14'(b), 14'(p)};
    idx  = '{cor_pkg::RegClipLeft, cor_pkg::RegClipTop, cor_pkg::RegClipRight,
             cor_pkg::RegClipBottom, cor_pkg::RegRowPitch};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
      case (idx[i])
        cor_pkg::RegClipLeft:   win_left   = vals[i][12:0];
        cor_pkg::RegClipTop:    win_top    = vals[i][12:0];
        cor_pkg::RegClipRight:  win_right  = vals[i][12:0];
        cor_pkg::RegClipBottom: win_bottom = vals[i][12:0];
        default:                pitch      = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_small_circles();
    next_pixel();                       // nothing active yet
    start_circle(10, 10, 0);
    walk_circle(10);
    next_pixel();                       // inactive again
    start_circle(0, 0, 1);
    walk_circle(20);
    start_circle(-1, -1, 2);
    walk_circle(30);
    start_circle(100, 200, 3);
    next_pixel();
    next_pixel();
    start_circle(4095, 4095, 3);        // abandons the previous circle
    walk_circle(40);
    wait_idle();
  endtask

  task automatic test_extreme_centres();
    start_circle(32767, -32768, 2047);  // fully clipped, long internal walk
    walk_circle(3);
    start_circle(-32768, 32767, 5);
    walk_circle(3);
    start_circle(2048, 2048, 2047);
    walk_circle(6);
    wait_idle();
  endtask

  task automatic test_odd_windows();
    set_window(8191, 8191, 8191, 8191, 16383);
    start_circle(8000, 8000, 300);
    walk_circle(5);
    wait_idle();
    set_window(4000, 4000, 8191, 8191, 0);
    start_circle(4200, 4200, 150);
    walk_circle(8);
    wait_idle();
    set_window(50, 50, 10, 10, 1);      // inverted window
    start_circle(30, 30, 20);
    walk_circle(4);
    wait_idle();
    set_window(0, 0, 4096, 4096, 8192);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    set_window(0, 0, 4096, 4096, 640);
    start_circle(300, 300, 40);
    hold_until = cyc + 400;
    for (int i = 0; i < 20; i++) next_pixel();
    walk_circle(400);
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_walks();
    int l, t, cx, cy, r, steps;
    for (int ph = 0; ph < 5 && n_items < 560; ph++) begin
      l = $urandom_range(0, 1000);
      t = $urandom_range(0, 1000);
      set_window(l, t, l + $urandom_range(1, 120), t + $urandom_range(1, 120),
                 $urandom_range(1, 8191));
      while (n_items < 120 * (ph + 1) + 30 && n_items < 560) begin
        if ($urandom_range(0, 19) == 0) begin
          // noise: any centre and radius, a couple of requests
          start_circle($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 2047));
          walk_circle($urandom_range(0, 2));
        end else begin
          cx = l - 20 + $urandom_range(0, 160);
          cy = t - 20 + $urandom_range(0, 160);
          r  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 15);
          steps = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 1000;
          start_circle(cx, cy, r);
          // keep the total close to the item budget
          if (steps > 560 - n_items) steps = 560 - n_items;
          walk_circle(steps);
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    win_left = 0; win_top = 0; win_right = 4096; win_bottom = 4096; pitch = 4096;
    walking = 1'b0; ctr_col = 0; ctr_row = 0; rad = 0; row_d = 0;
    run_o = 0; prev_left = 0; half_w = 0; phase = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    test_small_circles();
    test_extreme_centres();
    test_odd_windows();
    test_backpressure();
    test_random_walks();
    wait_idle();
    $display("covered %0d items: %0d pixels, %0d done results", n_items, n_pixels, n_dones);
    $display("clip windows incl. oversize, inverted and zero pitch, long output hold-off");
    if (err_cnt == 0) begin
      $display("PASS circle_outline_rasterizer");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL circle_outline_rasterizer");
    end
    $finish;
  end

endmodule
